[rtl/core/eabv_pkg.sv]
// ---------------------------------------------------------------------------
// eabv_pkg: shared types and constants
// Angle, CORDIC and matrix constants for the Euler basis vector unit.
// ---------------------------------------------------------------------------
package eabv_pkg;

  localparam int TabLen = 24;
  localparam int OutWidth = 16;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  // values are Q2.30 in 34 bits with headroom
  typedef logic signed [33:0] q30_t;

  typedef struct packed {
    q30_t s;
    q30_t c;
  } sincos_t;

  function automatic logic [31:0] atan_entry(input int i);
    logic [31:0] t;
    case (i)
      0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
      3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
      9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
      15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
      21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

  // Q2.30 product rounded half up
  function automatic q30_t qmul(input q30_t a, input q30_t b);
    logic signed [67:0] p;
    p = a * b + 68'sd536870912;
    return q30_t'(p >>> 30);
  endfunction

endpackage

[rtl/core/eabv_lane.sv]
// ---------------------------------------------------------------------------
// eabv_lane: one angle to sine and cosine
// Phase conversion with whole-turn wrap, quadrant fold, pipelined CORDIC.
// ---------------------------------------------------------------------------
module eabv_lane import eabv_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int TRIG_STAGES = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [17:0] ang,
  output sincos_t            res
);

  localparam int Stg = (TRIG_STAGES < TabLen) ? TRIG_STAGES : TabLen;
  localparam int Full = 360 << ANGLE_FRAC_BITS;
  // whole turns added so the angle is never negative; they vanish mod 2^32
  localparam int Offs = Full * ((131072 + Full - 1) / Full);
  // phase = floor((u*2^(32-F) + 180) / 360) = floor((u*2^Sh + 22) / 45)
  localparam int Sh = 29 - ANGLE_FRAC_BITS;
  localparam logic [22:0] Recip45A = 23'd5965233;     // ceil(2^28/45)
  localparam logic [31:0] Recip45B = 32'd3054198967;  // ceil(2^37/45)

  // stage 0: u = 45*a + b
  logic [21:0] u0;
  logic [44:0] pa0;
  logic [16:0] a0;
  logic [5:0]  b0;
  assign u0 = 22'(ang) + 22'(Offs);
  assign pa0 = 45'(u0) * 45'(Recip45A);
  assign a0 = 17'(pa0 >> 28);
  assign b0 = 6'(u0 - 22'(a0) * 22'd45);

  logic [16:0] a_r;
  logic [5:0]  b_r;
  always_ff @(posedge clk) if (en) begin
    a_r <= a0;
    b_r <= b0;
  end

  // stage 1: phase = a*2^Sh + floor((b*2^Sh + 22) / 45), mod 2^32
  logic [31:0] c1;
  logic [63:0] pb1;
  logic [31:0] ph1;
  assign c1 = (32'(b_r) << Sh) + 32'd22;
  assign pb1 = 64'(c1) * 64'(Recip45B);
  assign ph1 = 32'(64'(a_r) << Sh) + 32'(pb1 >> 37);
  logic [31:0] ph_r;
  always_ff @(posedge clk) if (en) ph_r <= ph1;

  // stage 2: quadrant fold
  logic [1:0] q2;
  logic [31:0] z2;
  assign q2 = 2'((ph_r + 32'h20000000) >> 30);
  assign z2 = ph_r - {q2, 30'd0};

  logic [1:0] quad_r [Stg+1];
  q30_t x_r [Stg+1];
  q30_t y_r [Stg+1];
  logic signed [32:0] z_r [Stg+1];

  always_ff @(posedge clk) if (en) begin
    quad_r[0] <= q2;
    x_r[0] <= CordicGain;
    y_r[0] <= '0;
    z_r[0] <= 33'(signed'(z2));
  end

  for (genvar i = 0; i < Stg; i++) begin : g_stg
    logic signed [32:0] at;
    assign at = 33'(atan_entry(i));
    always_ff @(posedge clk) if (en) begin
      quad_r[i+1] <= quad_r[i];
      if (z_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - at;
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + at;
      end
    end
  end

  always_ff @(posedge clk) if (en) begin
    case (quad_r[Stg])
      2'd0: begin res.c <= x_r[Stg]; res.s <= y_r[Stg]; end
      2'd1: begin res.c <= -y_r[Stg]; res.s <= x_r[Stg]; end
      2'd2: begin res.c <= -x_r[Stg]; res.s <= -y_r[Stg]; end
      default: begin res.c <= y_r[Stg]; res.s <= -x_r[Stg]; end
    endcase
  end

endmodule

[rtl/core/eabv_merge.sv]
// ---------------------------------------------------------------------------
// eabv_merge: matrix assembly
// Forms products of the three lanes' results and rounds, clamps outputs.
// ---------------------------------------------------------------------------
module eabv_merge import eabv_pkg::*; #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic    clk,
  input  logic    en,
  input  logic    cmd,
  input  sincos_t p,
  input  sincos_t y,
  input  sincos_t r,
  output logic [OutWidth-1:0] m [9]
);

  // stage A: pair products
  q30_t spcy_r, spsy_r, cpcy_r, cpsy_r, crsy_r, crcy_r, srsy_r, srcy_r;
  q30_t srcp_r, crcp_r, sp_r, sr_r, cr_r;
  logic cmd_a_r;
  always_ff @(posedge clk) if (en) begin
    spcy_r <= qmul(p.s, y.c);
    spsy_r <= qmul(p.s, y.s);
    cpcy_r <= qmul(p.c, y.c);
    cpsy_r <= qmul(p.c, y.s);
    crsy_r <= qmul(r.c, y.s);
    crcy_r <= qmul(r.c, y.c);
    srsy_r <= qmul(r.s, y.s);
    srcy_r <= qmul(r.s, y.c);
    srcp_r <= qmul(r.s, p.c);
    crcp_r <= qmul(r.c, p.c);
    sp_r <= p.s;
    sr_r <= r.s;
    cr_r <= r.c;
    cmd_a_r <= cmd;
  end

  // stage B: triple products and sums
  q30_t v [9];
  q30_t a, b, c, d;
  always_comb begin
    a = qmul(sr_r, spcy_r);
    b = qmul(sr_r, spsy_r);
    c = qmul(cr_r, spcy_r);
    d = qmul(cr_r, spsy_r);
    if (!cmd_a_r) begin
      v[0] = cpcy_r; v[1] = cpsy_r; v[2] = -sp_r;
      v[3] = -a + crsy_r; v[4] = -b - crcy_r; v[5] = -srcp_r;
      v[6] = c + srsy_r; v[7] = d - srcy_r; v[8] = crcp_r;
    end else begin
      v[0] = cpcy_r; v[1] = a - crsy_r; v[2] = c + srsy_r;
      v[3] = cpsy_r; v[4] = b + crcy_r; v[5] = d - srcy_r;
      v[6] = -sp_r; v[7] = srcp_r; v[8] = crcp_r;
    end
  end

  q30_t v_r [9];
  always_ff @(posedge clk) if (en) v_r <= v;

  // stage C: round and clamp
  localparam int Sh = 30 - OUT_FRAC_BITS;
  localparam q30_t Lim = q30_t'(1) <<< OUT_FRAC_BITS;
  for (genvar j = 0; j < 9; j++) begin : g_out
    q30_t o;
    always_comb begin
      o = (v_r[j] + (q30_t'(1) <<< (Sh - 1))) >>> Sh;
      if (o > Lim) o = Lim;
      if (o < -Lim) o = -Lim;
    end
    always_ff @(posedge clk) if (en) m[j] <= o[OutWidth-1:0];
  end

endmodule

[rtl/core/euler_angles_to_basis_vectors_unit.sv]
// ---------------------------------------------------------------------------
// euler_angles_to_basis_vectors_unit: Euler angles to rotation basis
// Three CORDIC lanes and a matrix merge stage, fully pipelined.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries cmd, pitch, yaw, roll (degrees,
//   ANGLE_FRAC_BITS fraction bits). A transfer happens when valid is high
//   and stall low. Each input yields one result transfer on out_*.
//   cmd 0: forward/right/up columns; cmd 1: matrix rows (transposed).
//   Outputs are Q1.OUT_FRAC_BITS, clamped to +/-1.0.
//   TRIG_STAGES is capped at 24. Throughput: one item per cycle while the
//   output is not stalled, set by the pipelined CORDIC lanes (one stage per
//   register) and the three-stage merge with at most one multiplier rank
//   per stage.
//   The whole pipeline advances as one unit: it moves whenever the output
//   register is empty or being taken. When the receiver stalls with a full
//   output, in_stall rises and every stage holds in place, so no data is
//   lost. Valid bits per stage mark which slots hold items; bubbles travel
//   with the pipeline.
//   Reset (rst_n low, synchronous) clears all valid bits; payload is not
//   reset.
// ---------------------------------------------------------------------------
module euler_angles_to_basis_vectors_unit import eabv_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int OUT_FRAC_BITS = 14,
  parameter int TRIG_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic signed [17:0] in_pitch,
  input  logic signed [17:0] in_yaw,
  input  logic signed [17:0] in_roll,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_first_x,
  output logic signed [15:0] out_first_y,
  output logic signed [15:0] out_first_z,
  output logic signed [15:0] out_second_x,
  output logic signed [15:0] out_second_y,
  output logic signed [15:0] out_second_z,
  output logic signed [15:0] out_third_x,
  output logic signed [15:0] out_third_y,
  output logic signed [15:0] out_third_z
);

  localparam int Stg = (TRIG_STAGES < TabLen) ? TRIG_STAGES : TabLen;
  // lane: 2 prep + 1 load + Stg + 1 fold regs; merge: 3 regs
  localparam int Lat = Stg + 7;

  logic en;
  logic [Lat-1:0] vld_r, vld_nxt;
  logic [Stg+3:0] cmd_r;

  // advance when the final slot is empty or being taken
  assign en = !vld_r[Lat-1] || !out_stall;
  assign in_stall = !en;

  always_comb begin
    vld_nxt = vld_r;
    if (en) vld_nxt = {vld_r[Lat-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= vld_nxt;
  end

  // cmd rides alongside the lanes until the merge stage
  always_ff @(posedge clk) if (en) cmd_r <= {cmd_r[Stg+2:0], in_cmd};

  sincos_t sc_p, sc_y, sc_r;

  eabv_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .TRIG_STAGES(TRIG_STAGES)) u_pitch (
    .clk(clk), .en(en), .ang(in_pitch), .res(sc_p));
  eabv_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .TRIG_STAGES(TRIG_STAGES)) u_yaw (
    .clk(clk), .en(en), .ang(in_yaw), .res(sc_y));
  eabv_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .TRIG_STAGES(TRIG_STAGES)) u_roll (
    .clk(clk), .en(en), .ang(in_roll), .res(sc_r));

  logic [OutWidth-1:0] m [9];

  eabv_merge #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_merge (
    .clk(clk), .en(en), .cmd(cmd_r[Stg+3]),
    .p(sc_p), .y(sc_y), .r(sc_r), .m(m));

  assign out_valid    = vld_r[Lat-1];
  assign out_first_x  = m[0];
  assign out_first_y  = m[1];
  assign out_first_z  = m[2];
  assign out_second_x = m[3];
  assign out_second_y = m[4];
  assign out_second_z = m[5];
  assign out_third_x  = m[6];
  assign out_third_y  = m[7];
  assign out_third_z  = m[8];

  // pipeline holds whenever the output is occupied and stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(vld_r))
    else $error("pipeline moved during stall");

  // input stalls only behind a held result
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (en && !$isunknown(in_valid)) |=> vld_r[0] == $past(in_valid))
    else $error("entry valid mismatch");

endmodule

[tb/testbench.sv]
// ---------------------------------------------------------------------------
// testbench: regression for euler_angles_to_basis_vectors_unit
// Drives a directed table of angle triples and then random orientations,
// with random idle bursts and a long stall on the result side. Each result
// transfer is checked field by field against a bit-exact CORDIC and matrix
// predictor, or against a typed-in basis for the zero-angle table rows.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import eabv_pkg::*;

  localparam int AngleFrac = 8;
  localparam int OutFrac = 14;
  localparam int Stages = 16;
  localparam int NumRandom = 1500;
  localparam int PipeDepth = Stages + 8;
  localparam longint FullTurn = 360 << AngleFrac;
  localparam longint Mask32 = 64'hFFFF_FFFF;
  localparam logic CmdColumns = 1'b0;
  localparam logic CmdRows = 1'b1;

  typedef logic [8:0][15:0] basis_t;

  typedef struct {
    logic               cmd;
    logic signed [17:0] pitch;
    logic signed [17:0] yaw;
    logic signed [17:0] roll;
    bit                 typed;
    basis_t             value;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_cmd = 1'b0;
  logic signed [17:0] in_pitch = '0;
  logic signed [17:0] in_yaw = '0;
  logic signed [17:0] in_roll = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_first_x, out_first_y, out_first_z;
  logic signed [15:0] out_second_x, out_second_y, out_second_z;
  logic signed [15:0] out_third_x, out_third_y, out_third_z;

  basis_t pending_basis[$];
  int     n_errors = 0;
  int     n_sent = 0;
  int     n_checked = 0;
  bit     quiet_tail = 1'b0;
  bit     stim_done = 1'b0;

  euler_angles_to_basis_vectors_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .in_pitch(in_pitch), .in_yaw(in_yaw), .in_roll(in_roll),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_first_x(out_first_x), .out_first_y(out_first_y),
    .out_first_z(out_first_z), .out_second_x(out_second_x),
    .out_second_y(out_second_y), .out_second_z(out_second_z),
    .out_third_x(out_third_x), .out_third_y(out_third_y),
    .out_third_z(out_third_z)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---- predictor ----------------------------------------------------------

  // Q2.30 product, rounded half up
  function automatic longint mul_q30(input longint a, input longint b);
    return (a * b + (longint'(1) << 29)) >>> 30;
  endfunction

  // wrap to one turn, snap to a quarter turn, CORDIC on the remainder
  function automatic void angle_trig(input logic signed [17:0] ang,
                                     output longint s, output longint c);
    longint          r, x, y, z, nx;
    longint unsigned ph, q, zu;
    r = longint'(ang) % FullTurn;
    if (r < 0) r += FullTurn;
    ph = ((longint'(r) << (32 - AngleFrac)) + 180) / 360 & Mask32;
    q = ((ph + 64'h2000_0000) >> 30) & 3;
    zu = (ph - (q << 30)) & Mask32;
    z = (zu >= 64'h8000_0000) ? longint'(zu) - (longint'(1) << 32) : longint'(zu);
    x = longint'(CordicGain);
    y = 0;
    for (int i = 0; i < Stages && i < TabLen; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(atan_entry(i));
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(atan_entry(i));
      end
      x = nx;
    end
    case (q)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  // round to the output fraction and clamp to +/-1.0
  function automatic logic [15:0] to_q14(input longint v);
    longint lim, o;
    lim = longint'(1) << OutFrac;
    o = (v + (longint'(1) << (29 - OutFrac))) >>> (30 - OutFrac);
    if (o > lim) o = lim;
    if (o < -lim) o = -lim;
    return o[15:0];
  endfunction

  // first_x lands in the top slot, third_z in slot zero
  function automatic basis_t rotation_basis(input logic cmd,
      input logic signed [17:0] p, input logic signed [17:0] yw,
      input logic signed [17:0] rl);
    longint sp, cp, sy, cy, sr, cr, spcy, spsy;
    longint m[9];
    basis_t b;
    angle_trig(p, sp, cp);
    angle_trig(yw, sy, cy);
    angle_trig(rl, sr, cr);
    spcy = mul_q30(sp, cy);
    spsy = mul_q30(sp, sy);
    if (cmd == CmdColumns) begin
      m[0] = mul_q30(cp, cy);
      m[1] = mul_q30(cp, sy);
      m[2] = -sp;
      m[3] = -mul_q30(sr, spcy) + mul_q30(cr, sy);
      m[4] = -mul_q30(sr, spsy) - mul_q30(cr, cy);
      m[5] = -mul_q30(sr, cp);
      m[6] = mul_q30(cr, spcy) + mul_q30(sr, sy);
      m[7] = mul_q30(cr, spsy) - mul_q30(sr, cy);
      m[8] = mul_q30(cr, cp);
    end else begin
      m[0] = mul_q30(cp, cy);
      m[1] = mul_q30(sr, spcy) - mul_q30(cr, sy);
      m[2] = mul_q30(cr, spcy) + mul_q30(sr, sy);
      m[3] = mul_q30(cp, sy);
      m[4] = mul_q30(sr, spsy) + mul_q30(cr, cy);
      m[5] = mul_q30(cr, spsy) - mul_q30(sr, cy);
      m[6] = -sp;
      m[7] = mul_q30(sr, cp);
      m[8] = mul_q30(cr, cp);
    end
    for (int j = 0; j < 9; j++) b[8 - j] = to_q14(m[j]);
    return b;
  endfunction

  // ---- directed table -----------------------------------------------------
  // zero angles give the identity (rows) or diag(1,-1,1) (columns), typed in; the rest use the predictor
  localparam basis_t IdColumns = {16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384,
                                  16'sd0, 16'sd0, 16'sd0, 16'sd16384};
  localparam basis_t IdRows = {16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384,
                               16'sd0, 16'sd0, 16'sd0, 16'sd16384};

  row_t directed[] = '{
    '{CmdColumns, 18'sd0, 18'sd0, 18'sd0, 1'b1, IdColumns},
    '{CmdRows, 18'sd0, 18'sd0, 18'sd0, 1'b1, IdRows},
    '{CmdColumns, 18'sd92160, 18'sd0, 18'sd0, 1'b0, '0},
    '{CmdRows, -18'sd92160, 18'sd92160, -18'sd92160, 1'b0, '0},
    '{CmdColumns, 18'sd131071, 18'sd131071, 18'sd131071, 1'b0, '0},
    '{CmdRows, -18'sd131072, -18'sd131072, -18'sd131072, 1'b0, '0},
    '{CmdColumns, 18'sd23040, 18'sd0, 18'sd0, 1'b0, '0},
    '{CmdColumns, -18'sd23040, 18'sd0, 18'sd0, 1'b0, '0},
    '{CmdRows, 18'sd0, 18'sd23040, 18'sd0, 1'b0, '0},
    '{CmdRows, 18'sd0, 18'sd0, 18'sd23040, 1'b0, '0},
    '{CmdColumns, 18'sd46080, 18'sd46080, 18'sd46080, 1'b0, '0},
    '{CmdRows, 18'sd69120, -18'sd69120, 18'sd69120, 1'b0, '0},
    '{CmdColumns, 18'sd11520, 18'sd11520, 18'sd11520, 1'b0, '0},
    '{CmdRows, 18'sd11520, -18'sd11520, 18'sd11520, 1'b0, '0},
    '{CmdColumns, 18'sd1, -18'sd1, 18'sd1, 1'b0, '0},
    '{CmdRows, 18'sd92159, 18'sd92161, -18'sd92161, 1'b0, '0},
    '{CmdColumns, 18'sd5760, 18'sd17280, 18'sd28800, 1'b0, '0},
    '{CmdRows, 18'sd5760, 18'sd17280, 18'sd28800, 1'b0, '0},
    '{CmdColumns, 18'sd22912, 18'sd23168, -18'sd23168, 1'b0, '0},
    '{CmdRows, -18'sd46080, 18'sd115200, -18'sd115200, 1'b0, '0}
  };

  // ---- checking -----------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    n_errors++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what,
             $signed(got), $signed(want), $realtime);
  endtask

  // result side: compare every transfer with the oldest pending basis
  initial begin
    string  names[9] = '{"third_z", "third_y", "third_x", "second_z",
                         "second_y", "second_x", "first_z", "first_y", "first_x"};
    basis_t got, want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got = {out_first_x, out_first_y, out_first_z, out_second_x, out_second_y,
               out_second_z, out_third_x, out_third_y, out_third_z};
        if (pending_basis.size() == 0) begin
          n_errors++;
          $display("MISMATCH unexpected result transfer at %0t", $realtime);
        end else begin
          want = pending_basis.pop_front();
          n_checked++;
          for (int j = 0; j < 9; j++)
            if (got[j] !== want[j]) report_mismatch(names[j], got[j], want[j]);
        end
      end
    end
  end

  // ---- stimulus -----------------------------------------------------------

  // one input transfer; the expected basis is queued at the accepting edge
  task automatic send_item(input logic cmd, input logic signed [17:0] p,
                           input logic signed [17:0] yw,
                           input logic signed [17:0] rl,
                           input bit typed, input basis_t value);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_cmd = cmd;
    in_pitch = p;
    in_yaw = yw;
    in_roll = rl;
    do @(posedge clk); while (in_stall);
    pending_basis.push_back(typed ? value : rotation_basis(cmd, p, yw, rl));
    n_sent++;
    @(negedge clk);
  endtask

  function automatic logic signed [17:0] pick_angle();
    case ($urandom_range(0, 4))
      0: return 18'($urandom);
      1: return 18'($signed($urandom_range(0, 184320)) - 92160);
      2: return 18'($signed($urandom_range(0, 8) * 11520) - 46080);
      3: return 18'($signed($urandom_range(0, 8) * 11520 + $urandom_range(0, 8))
                    - 46084);
      default: return 18'($signed($urandom_range(0, 4096)) - 2048);
    endcase
  endfunction

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    foreach (directed[k])
      send_item(directed[k].cmd, directed[k].pitch, directed[k].yaw,
                directed[k].roll, directed[k].typed, directed[k].value);
    for (int k = 0; k < NumRandom; k++) begin
      if (k == NumRandom - 200) quiet_tail = 1'b1;
      send_item(1'($urandom), pick_angle(), pick_angle(), pick_angle(), 1'b0, '0);
    end
    in_valid = 1'b0;
    stim_done = 1'b1;
  end

  // receiver: random stall bursts, one long hold-off to back up the pipe
  initial begin
    int  hold;
    bit  held_long = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_long && n_sent >= 300) begin
        held_long = 1'b1;
        out_stall = 1'b1;
        for (hold = 0; hold < 3 * PipeDepth; hold++) @(negedge clk);
        out_stall = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // ---- end of run ---------------------------------------------------------

  initial begin
    wait (stim_done);
    while (pending_basis.size() != 0) @(posedge clk);
    repeat (2 * PipeDepth) @(posedge clk);
    if (pending_basis.size() != 0) begin
      n_errors++;
      $display("MISMATCH %0d results never arrived", pending_basis.size());
    end
    $display("Ran %0d orientations (table, wrapped and random angles, both cmd forms)",
             n_sent);
    $display("Checked %0d result transfers, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("euler_angles_to_basis_vectors_unit regression: pass");
    end else begin
      $display("euler_angles_to_basis_vectors_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results outstanding", pending_basis.size());
    $display("euler_angles_to_basis_vectors_unit regression: fail");
    $finish;
  end

endmodule

[files.f]
rtl/core/eabv_pkg.sv
rtl/core/eabv_lane.sv
rtl/core/eabv_merge.sv
rtl/core/euler_angles_to_basis_vectors_unit.sv
tb/testbench.sv
